@@ rtl/hermite_spline_sampler_unit_defines.svh @@
// Assertion macros for the Hermite spline sampler.
// Used by the top level; no other dependencies.
`ifndef HERMITE_SPLINE_SAMPLER_UNIT_DEFINES_SVH
`define HERMITE_SPLINE_SAMPLER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// The condition must hold at every clock edge out of reset.
`define HSS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("hermite sampler: invariant violated");
// The consequent must hold in the cycle after the antecedent.
`define HSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hermite sampler: sequence check failed");
`else
`define HSS_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define HSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/hss_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types of the Hermite spline sampler.
// No dependencies; used by hss_eval and the top level.
package hss_pkg;

    // Default sizing of the block.
    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 32;

    // Fixed point format of the curve parameter and of the coordinates.
    localparam int FRAC_BITS  = 16;
    localparam int TW         = 17;
    localparam int ONE_Q16    = 65536;
    localparam int ROUND_HALF = 32768;

    // Width of the signed basis weights.
    localparam int HW = 19;

    // Fewest points that form a curve.
    localparam int MIN_POINTS = 2;

    localparam logic [TW-1:0] T_STEP_RESET = 17'd66;

    // Request codes.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EMIT = 1'b1;

    // Controls from the sequencer to the evaluation datapath.
    typedef struct packed {
        logic sq_en;
        logic cube_en;
        logic ld_p1;
        logic ld_p2;
        logic ld_diff;
        logic last_seg;
        logic prod_en;
        logic sum_en;
    } t_eval_ctl;

endpackage

@@ rtl/hss_point_mem.sv @@
`timescale 1ns / 1ps
// Control point store: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module hss_point_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 96,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/hss_eval.sv @@
`timescale 1ns / 1ps
// Evaluation datapath: basis weights, point differences, products and saturation.
// Depends on hss_pkg; sequenced by the top level through hss_pkg::t_eval_ctl.
module hss_eval #(
    parameter int COORD_BITS = hss_pkg::COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  hss_pkg::t_eval_ctl        i_ctl,
    input  logic [hss_pkg::TW-1:0]    i_t,
    input  logic [3*COORD_BITS-1:0]   i_rd_data,
    output logic [3*COORD_BITS-1:0]   o_res
);

    localparam int TW  = hss_pkg::TW;
    localparam int HW  = hss_pkg::HW;
    localparam int DW  = COORD_BITS + 1;
    localparam int PW  = DW + HW;
    localparam int SW  = PW + 1;
    localparam int VW  = SW - hss_pkg::FRAC_BITS + 1;
    localparam logic [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic [2*TW-1:0]               r_tt;
    logic [TW-1:0]                 r_t2;
    logic [2*TW-1:0]               r_t3p;
    logic signed [HW-1:0]          r_ha;
    logic signed [HW-1:0]          r_h4;
    logic signed [COORD_BITS-1:0]  r_p1   [3];
    logic signed [COORD_BITS-1:0]  r_p2   [3];
    logic signed [DW-1:0]          r_d    [3];
    logic signed [DW-1:0]          r_tan2 [3];
    logic signed [PW-1:0]          r_ma;
    logic signed [PW-1:0]          r_mb;
    logic signed [COORD_BITS-1:0]  r_res  [3];

    logic [2*TW-1:0]               tt_rnd;
    logic [2*TW-1:0]               t3_rnd;
    logic [TW-1:0]                 t2_n;
    logic [TW-1:0]                 t3_n;
    logic [HW-1:0]                 t_w;
    logic [HW-1:0]                 t2_w;
    logic [HW-1:0]                 t3_w;
    logic signed [COORD_BITS-1:0]  rd_c   [3];
    logic signed [DW-1:0]          d_n    [3];
    logic signed [DW-1:0]          n3_n   [3];
    logic signed [SW-1:0]          s_n;
    logic signed [SW-1:0]          sh_n;
    logic signed [VW-1:0]          v_n;
    logic                          ovf_n;
    logic [COORD_BITS-1:0]         sat_n;

    // Rounded square and cube of t, each in Q.16.
    always_comb begin
        tt_rnd = r_tt + (2*TW)'(hss_pkg::ROUND_HALF);
        t2_n   = tt_rnd[hss_pkg::FRAC_BITS +: TW];
        t3_rnd = r_t3p + (2*TW)'(hss_pkg::ROUND_HALF);
        t3_n   = t3_rnd[hss_pkg::FRAC_BITS +: TW];
        t_w    = HW'(i_t);
        t2_w   = HW'(r_t2);
        t3_w   = HW'(t3_n);
    end

    // Since the incoming tangent equals the chord, h2 and h3 share one product.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            rd_c[c] = $signed(i_rd_data[c*COORD_BITS +: COORD_BITS]);
            d_n[c]  = DW'(r_p2[c]) - DW'(r_p1[c]);
            n3_n[c] = DW'(rd_c[c]) - DW'(r_p2[c]);
        end
    end

    // Sum the two products, round once, add the start point and saturate.
    always_comb begin
        s_n   = SW'(r_ma) + SW'(r_mb) + SW'(hss_pkg::ROUND_HALF);
        sh_n  = s_n >>> hss_pkg::FRAC_BITS;
        v_n   = VW'(r_p1[0]) + VW'(sh_n);
        ovf_n = !((&v_n[VW-1:COORD_BITS-1]) || !(|v_n[VW-1:COORD_BITS-1]));
        if (ovf_n) begin
            sat_n = v_n[VW-1] ? C_MIN : C_MAX;
        end else begin
            sat_n = v_n[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sq_en) begin
            r_tt <= i_t * i_t;
        end
        if (i_ctl.cube_en) begin
            r_t2  <= t2_n;
            r_t3p <= t2_n * i_t;
        end
        if (i_ctl.ld_diff) begin
            r_ha <= $signed(t_w + t2_w - t3_w);
            r_h4 <= $signed(t3_w - t2_w);
        end
        // The coordinate vectors move down one place per product or sum step.
        for (int c = 0; c < 3; c++) begin
            if (i_ctl.ld_p1) begin
                r_p1[c] <= rd_c[c];
            end else if (i_ctl.sum_en) begin
                r_p1[c] <= (c == 2) ? r_p1[c] : r_p1[(c + 1) % 3];
            end
            if (i_ctl.ld_p2) begin
                r_p2[c] <= rd_c[c];
            end
            if (i_ctl.ld_diff) begin
                r_d[c]    <= d_n[c];
                r_tan2[c] <= i_ctl.last_seg ? d_n[c] : n3_n[c];
            end else if (i_ctl.prod_en) begin
                r_d[c]    <= (c == 2) ? r_d[c] : r_d[(c + 1) % 3];
                r_tan2[c] <= (c == 2) ? r_tan2[c] : r_tan2[(c + 1) % 3];
            end
            if (i_ctl.sum_en) begin
                r_res[c] <= (c == 2) ? $signed(sat_n) : r_res[(c + 1) % 3];
            end
        end
        if (i_ctl.prod_en) begin
            r_ma <= r_ha * r_d[0];
            r_mb <= r_h4 * r_tan2[0];
        end
    end

    assign o_res = {r_res[2], r_res[1], r_res[0]};

endmodule

@@ rtl/hermite_spline_sampler_unit.sv @@
`timescale 1ns / 1ps
// Top level of the Hermite spline sampler: handshakes, cursor state and sequencer.
// Depends on hss_pkg, hss_point_mem, hss_eval and the assertion macro header.

// This unit stores up to MAX_POINTS 3D control points in a single-port-read
// memory and, on each emit item, returns the next sample of the cubic Hermite
// curve through them, with forward-difference tangents and a backward
// difference at the final point. A load item leaves the unit idle, so the next
// item can enter in the following cycle. An emit item runs from acceptance to
// the next acceptance through these steps: reading the segment's three points
// through the one read port of the point memory (the basis weights are formed
// alongside), the shared pair of multipliers working through x, y and z with
// the rounding sum trailing behind, loading the output register, and the idle
// state in which the next item is taken. The output register step stretches
// while a previous result is still held by a stalled output. An emit on a list
// of fewer than two points goes straight to the output register step and
// returns a result flagged no_curve with zero coordinates. The point memory
// needs no clearing after reset, because no entry at or above the point count
// ever reaches a result. The t_step register may be written at any time the
// unit is idle; a value of zero acts as one.
`include "hermite_spline_sampler_unit_defines.svh"

module hermite_spline_sampler_unit #(
    parameter int MAX_POINTS = hss_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = hss_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration write port for t_step.
    input  logic                         i_cfg_wr_en,
    input  logic [hss_pkg::TW-1:0]       i_cfg_wr_data,
    // Input channel.
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_req_type,
    input  logic                         i_first_point,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_point_z,
    // Output channel.
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [COORD_BITS-1:0] o_curve_x,
    output logic signed [COORD_BITS-1:0] o_curve_y,
    output logic signed [COORD_BITS-1:0] o_curve_z,
    output logic                         o_last_of_curve,
    output logic                         o_no_curve
);

    localparam int TW = hss_pkg::TW;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [1:0] MAC_LAST = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_RD3,
        S_MAC,
        S_DONE
    } t_state;

    t_state                       r_state;
    logic [CW-1:0]                r_count;
    logic [AW-1:0]                r_seg;
    logic [TW-1:0]                r_t_accum;
    logic [TW-1:0]                r_t_step;
    logic [1:0]                   r_mac_cnt;
    logic                         r_o_valid;
    // Working copy of the cursor for the emit item in flight.
    logic [AW-1:0]                r_cur_seg;
    logic [TW-1:0]                r_cur_t;
    logic                         r_cur_last;
    logic                         r_cur_end;
    logic                         r_cur_none;
    // Output payload.
    logic signed [COORD_BITS-1:0] r_o_x;
    logic signed [COORD_BITS-1:0] r_o_y;
    logic signed [COORD_BITS-1:0] r_o_z;
    logic                         r_o_last;
    logic                         r_o_none;

    logic                         in_acc;
    logic                         out_acc;
    logic                         is_emit;
    logic                         done_fire;
    logic [CW-1:0]                cnt_eff;
    logic                         no_pts;
    logic                         restart;
    logic [AW-1:0]                seg_eff;
    logic [TW-1:0]                t_eff;
    logic                         last_eff;
    logic [TW-1:0]                step_eff;
    logic [TW:0]                  t_next;
    logic                         seg_end;
    logic                         mem_we;
    logic                         mem_re;
    logic [AW-1:0]                mem_raddr;
    logic [3*COORD_BITS-1:0]      mem_rdata;
    logic [3*COORD_BITS-1:0]      eval_res;
    hss_pkg::t_eval_ctl           ctl;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = r_o_valid && !i_out_stall;
    assign is_emit    = (i_req_type == hss_pkg::REQ_EMIT);
    assign done_fire  = (r_state == S_DONE) && (!r_o_valid || out_acc);

    // Cursor arithmetic for an emit. A cursor past the list, or a parameter
    // past one, starts the curve over at its first segment.
    always_comb begin
        cnt_eff  = i_first_point ? '0 : r_count;
        mem_we   = in_acc && !is_emit && (cnt_eff < CW'(MAX_POINTS));
        no_pts   = r_count < CW'(hss_pkg::MIN_POINTS);
        restart  = (CW'(r_seg) >= r_count - CW'(1)) ||
                   (r_t_accum > TW'(hss_pkg::ONE_Q16));
        seg_eff  = restart ? '0 : r_seg;
        t_eff    = restart ? '0 : r_t_accum;
        last_eff = (CW'(seg_eff) == r_count - CW'(hss_pkg::MIN_POINTS));
        step_eff = (r_t_step == '0) ? TW'(1) : r_t_step;
        t_next   = {1'b0, t_eff} + {1'b0, step_eff};
        seg_end  = t_next > (TW+1)'(hss_pkg::ONE_Q16);
    end

    // Read address sequence: start point, end point, then the point after.
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = seg_eff;
        unique case (r_state)
            S_IDLE: begin
                mem_re    = in_acc && is_emit && !no_pts;
                mem_raddr = seg_eff;
            end
            S_RD1: begin
                mem_re    = 1'b1;
                mem_raddr = r_cur_seg + AW'(1);
            end
            S_RD2: begin
                mem_re    = 1'b1;
                mem_raddr = r_cur_seg + AW'(2);
            end
            default: begin
                mem_re    = 1'b0;
                mem_raddr = r_cur_seg;
            end
        endcase
    end

    always_comb begin
        ctl          = '0;
        ctl.last_seg = r_cur_last;
        ctl.sq_en    = (r_state == S_RD1);
        ctl.ld_p1    = (r_state == S_RD1);
        ctl.cube_en  = (r_state == S_RD2);
        ctl.ld_p2    = (r_state == S_RD2);
        ctl.ld_diff  = (r_state == S_RD3);
        ctl.prod_en  = (r_state == S_MAC) && (r_mac_cnt != MAC_LAST);
        ctl.sum_en   = (r_state == S_MAC) && (r_mac_cnt != 2'd0);
    end

    hss_point_mem #(
        .DEPTH (MAX_POINTS),
        .WIDTH (3 * COORD_BITS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (cnt_eff[AW-1:0]),
        .i_wr_data ({i_point_z, i_point_y, i_point_x}),
        .i_rd_en   (mem_re),
        .i_rd_addr (mem_raddr),
        .o_rd_data (mem_rdata)
    );

    hss_eval #(
        .COORD_BITS (COORD_BITS)
    ) u_eval (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_t       (r_cur_t),
        .i_rd_data (mem_rdata),
        .o_res     (eval_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_seg     <= '0;
            r_t_accum <= '0;
            r_t_step  <= hss_pkg::T_STEP_RESET;
            r_mac_cnt <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_t_step <= i_cfg_wr_data;
            end
            // A finishing emit refills the output register in the cycle it drains.
            if (done_fire) begin
                r_o_valid <= 1'b1;
            end else if (out_acc) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && !is_emit) begin
                        // A first point restarts the list with itself and rewinds the cursor.
                        if (i_first_point) begin
                            r_seg     <= '0;
                            r_t_accum <= '0;
                        end
                        r_count <= mem_we ? cnt_eff + CW'(1) : cnt_eff;
                    end else if (in_acc && no_pts) begin
                        r_cur_none <= 1'b1;
                        r_cur_end  <= 1'b0;
                        r_state    <= S_DONE;
                    end else if (in_acc) begin
                        // The cursor advances at acceptance; the datapath works
                        // from the working copy.
                        r_cur_none <= 1'b0;
                        r_cur_seg  <= seg_eff;
                        r_cur_t    <= t_eff;
                        r_cur_last <= last_eff;
                        r_cur_end  <= seg_end && last_eff;
                        if (seg_end) begin
                            r_t_accum <= '0;
                            r_seg     <= last_eff ? '0 : seg_eff + AW'(1);
                        end else begin
                            r_t_accum <= t_next[TW-1:0];
                            r_seg     <= seg_eff;
                        end
                        r_state <= S_RD1;
                    end
                end
                S_RD1: begin
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_state <= S_RD3;
                end
                S_RD3: begin
                    r_mac_cnt <= '0;
                    r_state   <= S_MAC;
                end
                S_MAC: begin
                    r_mac_cnt <= r_mac_cnt + 2'd1;
                    if (r_mac_cnt == MAC_LAST) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (done_fire) begin
                        r_o_x     <= r_cur_none ? '0 : $signed(eval_res[0 +: COORD_BITS]);
                        r_o_y     <= r_cur_none ? '0 :
                                     $signed(eval_res[COORD_BITS +: COORD_BITS]);
                        r_o_z     <= r_cur_none ? '0 :
                                     $signed(eval_res[2*COORD_BITS +: COORD_BITS]);
                        r_o_last  <= r_cur_end && !r_cur_none;
                        r_o_none  <= r_cur_none;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_curve_x       = r_o_x;
    assign o_curve_y       = r_o_y;
    assign o_curve_z       = r_o_z;
    assign o_last_of_curve = r_o_last;
    assign o_no_curve      = r_o_none;

    // The point count never passes the capacity of the store.
    `HSS_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(MAX_POINTS))
    // The stored parameter never passes one.
    `HSS_ASSERT_ALWAYS(a_t_bound, i_clk, i_rst_n, r_t_accum <= TW'(hss_pkg::ONE_Q16))
    // A finished emit always shows up on the output in the next cycle.
    `HSS_ASSERT_NEXT(a_done_shows, i_clk, i_rst_n, done_fire, o_out_valid)
    // A curve end is never flagged on a result that has no curve.
    `HSS_ASSERT_ALWAYS(a_last_vs_none, i_clk, i_rst_n, !(o_out_valid && o_last_of_curve && o_no_curve))

endmodule
